### design/pkst_pkg.sv
package pkst_pkg;

  localparam int unsigned IP_W       = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned MAX_KNOCKS = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LEN_RESET  = 3;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } rule_cmd_e;

  typedef enum logic [2:0] {
    ST_IN_PROGRESS  = 3'd0,
    ST_COMPLETE     = 3'd1,
    ST_OUT_OF_ORDER = 3'd2,
    ST_BAD_HASH     = 3'd3,
    ST_TABLE_FULL   = 3'd4
  } knock_status_e;

  typedef enum logic [2:0] {
    REG_SEQ_LEN = 3'd0,
    REG_PORT_0  = 3'd1,
    REG_PORT_1  = 3'd2,
    REG_PORT_2  = 3'd3,
    REG_PORT_3  = 3'd4,
    REG_PORT_4  = 3'd5,
    REG_PORT_5  = 3'd6
  } cfg_reg_e;

  // Configuration as seen by the tables (length already clamped)
  typedef struct packed {
    logic [CNT_W-1:0]                   seq_len;
    logic [MAX_KNOCKS-1:0][PORT_W-1:0]  ports;
  } cfg_t;

  // Outcome of the tracking table lookup for one knock
  typedef struct packed {
    logic full;
    logic done;
    logic mismatch;
  } trk_res_t;

  // Outcome of the open set lookup for one source
  typedef struct packed {
    logic found;
    logic full;
  } opn_res_t;

endpackage

### design/pkst_if.sv
interface pkst_knock_if;
  import pkst_pkg::*;

  logic              valid;
  logic              ready;
  logic [IP_W-1:0]   source_ip;
  logic [PORT_W-1:0] dest_port;
  logic              hash_valid;

  modport source (output valid, output source_ip, output dest_port, output hash_valid,
                  input ready);
  modport sink   (input valid, input source_ip, input dest_port, input hash_valid,
                  output ready);
endinterface

interface pkst_result_if;
  import pkst_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      rule_command;
  logic [IP_W-1:0] rule_ip;
  logic [2:0]      knock_status;

  modport source (output valid, output rule_command, output rule_ip, output knock_status,
                  input ready);
  modport sink   (input valid, input rule_command, input rule_ip, input knock_status,
                  output ready);
endinterface

### design/port_knock_sequence_tracker_core.sv
// The knock is captured in the input register and its outcome in the result register.
// Throughput: one knock per cycle unless a result waits on a stalled result side; both
// tables are searched in parallel in flip-flops, so the single lookup-and-update stage
// between the two registers sets the rate.
// Reset: asynchronous, active low; clears all table valid bits at once and restores
// sequence length 3 and all knock ports 0. No clearing pass is needed.
module port_knock_sequence_tracker_core #(
  parameter int unsigned TRACK_ENTRIES = 16,
  parameter int unsigned OPEN_ENTRIES  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pkst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pkst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pkst_knock_if.sink                      knock_i,
  pkst_result_if.source                   result_o
);
  import pkst_pkg::*;

  cfg_t     cfg;
  trk_res_t trk;
  opn_res_t opn;

  logic              s1_vld_q;
  logic [IP_W-1:0]   s1_ip_q;
  logic [PORT_W-1:0] s1_port_q;
  logic              s1_hash_q;
  logic              advance;
  logic              open_toggle;

  logic            out_vld_q;
  rule_cmd_e       out_cmd_q, out_cmd_d;
  logic [IP_W-1:0] out_ip_q;
  knock_status_e   out_st_q, out_st_d;

  pkst_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pkst_track #(.ENTRIES(TRACK_ENTRIES)) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .ip_i   (s1_ip_q),
    .port_i (s1_port_q),
    .hash_i (s1_hash_q),
    .cfg_i  (cfg),
    .res_o  (trk)
  );

  pkst_open #(.ENTRIES(OPEN_ENTRIES)) u_open (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .toggle_i (open_toggle),
    .ip_i     (s1_ip_q),
    .res_o    (opn)
  );

  // Advance the held knock whenever the result register is free or draining
  assign advance       = s1_vld_q && (!out_vld_q || result_o.ready);
  assign knock_i.ready = !s1_vld_q || advance;
  assign open_toggle   = advance && s1_hash_q && !trk.full && trk.done && !trk.mismatch;

  // Resolve command and status
  always_comb begin
    out_cmd_d = CMD_NONE;
    out_st_d  = ST_IN_PROGRESS;
    if (!s1_hash_q) begin
      out_st_d = ST_BAD_HASH;
    end else if (trk.full) begin
      out_st_d = ST_TABLE_FULL;
    end else if (!trk.done) begin
      out_st_d = ST_IN_PROGRESS;
    end else if (trk.mismatch) begin
      out_st_d = ST_OUT_OF_ORDER;
    end else if (opn.found) begin
      out_cmd_d = CMD_CLOSE;
      out_st_d  = ST_COMPLETE;
    end else if (!opn.full) begin
      out_cmd_d = CMD_OPEN;
      out_st_d  = ST_COMPLETE;
    end else begin
      out_st_d = ST_TABLE_FULL;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (knock_i.ready) s1_vld_q <= knock_i.valid;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture knock on transfer, result on advance
  always_ff @(posedge clk_i) begin
    if (knock_i.valid && knock_i.ready) begin
      s1_ip_q   <= knock_i.source_ip;
      s1_port_q <= knock_i.dest_port;
      s1_hash_q <= knock_i.hash_valid;
    end
    if (advance) begin
      out_cmd_q <= out_cmd_d;
      out_ip_q  <= s1_ip_q;
      out_st_q  <= out_st_d;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.rule_command = out_cmd_q;
  assign result_o.rule_ip      = out_ip_q;
  assign result_o.knock_status = out_st_q;

`ifndef SYNTH
  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_vld_q))
    else $error("result appeared without a held knock");

  a_cmd_needs_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_cmd_q != CMD_NONE) |-> (out_st_q == ST_COMPLETE))
    else $error("rule command without a completed sequence");

  a_ip_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_ip_q == $past(s1_ip_q)))
    else $error("result address differs from knock source");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !result_o.ready) |-> !knock_i.ready)
    else $error("knock taken while both stages are stalled");
`endif

endmodule

### design/pkst_cfg.sv
module pkst_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pkst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pkst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pkst_pkg::cfg_t                 cfg_o
);
  import pkst_pkg::*;

  logic [CNT_W-1:0]                  len_q;
  logic [MAX_KNOCKS-1:0][PORT_W-1:0] ports_q;
  logic [CFG_IDX_W-1:0]              port_sel;

  assign port_sel = cfg_idx_i - CFG_IDX_W'(1);

  // Decode register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= CNT_W'(LEN_RESET);
      ports_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i)) inside
        REG_SEQ_LEN: len_q <= cfg_data_i[CNT_W-1:0];
        REG_PORT_0, REG_PORT_1, REG_PORT_2, REG_PORT_3, REG_PORT_4, REG_PORT_5: begin
          ports_q[port_sel] <= cfg_data_i[PORT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Clamp the sequence length into one to the maximum
  always_comb begin
    cfg_o.ports = ports_q;
    if (len_q == '0) begin
      cfg_o.seq_len = CNT_W'(1);
    end else if (len_q > CNT_W'(MAX_KNOCKS)) begin
      cfg_o.seq_len = CNT_W'(MAX_KNOCKS);
    end else begin
      cfg_o.seq_len = len_q;
    end
  end

endmodule

### design/pkst_track.sv
module pkst_track #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [pkst_pkg::IP_W-1:0]   ip_i,
  input  logic [pkst_pkg::PORT_W-1:0] port_i,
  input  logic                        hash_i,
  input  pkst_pkg::cfg_t              cfg_i,
  output pkst_pkg::trk_res_t          res_o
);
  import pkst_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0]            vld_q;
  logic [ENTRIES-1:0][IP_W-1:0]  ip_q;
  logic [ENTRIES-1:0][CNT_W-1:0] cnt_q;
  logic [ENTRIES-1:0]            mis_q;

  logic [ENTRIES-1:0] hit_vec;
  logic               hit_any;
  logic               free_any;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      slot;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W:0]     pos_nx;
  logic               port_ok;
  logic               mis_nx;
  logic               done;
  logic               have_slot;

  // Associative match and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = vld_q[i] && (ip_q[i] == ip_i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IW'(i);
      if (!vld_q[i]) free_idx = IW'(i);
    end
    hit_any   = |hit_vec;
    free_any  = ~&vld_q;
    have_slot = hit_any || free_any;
    slot      = hit_any ? hit_idx : free_idx;
  end

  // Check the knock against the expected port and advance the count
  always_comb begin
    pos     = hit_any ? cnt_q[hit_idx] : '0;
    port_ok = (pos < CNT_W'(MAX_KNOCKS)) ? (port_i == cfg_i.ports[pos]) : 1'b0;
    mis_nx  = (hit_any && mis_q[hit_idx]) || !port_ok;
    pos_nx  = {1'b0, pos} + (CNT_W + 1)'(1);
    done    = pos_nx >= {1'b0, cfg_i.seq_len};

    res_o.full     = !have_slot;
    res_o.done     = done;
    res_o.mismatch = mis_nx;
  end

  // Hold valid bits; a bad hash or a finished sequence frees the slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      if (!hash_i) begin
        if (hit_any) vld_q[hit_idx] <= 1'b0;
      end else if (have_slot) begin
        vld_q[slot] <= !done;
      end
    end
  end

  // Slot contents
  always_ff @(posedge clk_i) begin
    if (en_i && hash_i && have_slot) begin
      ip_q[slot]  <= ip_i;
      cnt_q[slot] <= pos_nx[CNT_W-1:0];
      mis_q[slot] <= mis_nx;
    end
  end

endmodule

### design/pkst_open.sv
module pkst_open #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      toggle_i,
  input  logic [pkst_pkg::IP_W-1:0] ip_i,
  output pkst_pkg::opn_res_t        res_o
);
  import pkst_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0]           vld_q;
  logic [ENTRIES-1:0][IP_W-1:0] ip_q;

  logic [ENTRIES-1:0] hit_vec;
  logic               hit_any;
  logic               free_any;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      free_idx;

  // Associative match and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = vld_q[i] && (ip_q[i] == ip_i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IW'(i);
      if (!vld_q[i]) free_idx = IW'(i);
    end
    hit_any     = |hit_vec;
    free_any    = ~&vld_q;
    res_o.found = hit_any;
    res_o.full  = !free_any;
  end

  // Toggle membership: drop a present source, add an absent one if room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (toggle_i) begin
      if (hit_any) begin
        vld_q[hit_idx] <= 1'b0;
      end else if (free_any) begin
        vld_q[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (toggle_i && !hit_any && free_any) begin
      ip_q[free_idx] <= ip_i;
    end
  end

endmodule

### tb/sv/pkst_knock_checker.sv
module pkst_knock_checker #(
  parameter int unsigned TRACK_ENTRIES = 16,
  parameter int unsigned OPEN_ENTRIES  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pkst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pkst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pkst_knock_if                           knock_i,
  pkst_result_if                          result_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     knocks_o,
  output int unsigned                     opens_o,
  output int unsigned                     closes_o,
  output int unsigned                     disorder_o,
  output int unsigned                     bad_hash_o,
  output int unsigned                     full_hits_o
);
  import pkst_pkg::*;

  typedef struct packed {
    rule_cmd_e       cmd;
    logic [IP_W-1:0] ip;
    knock_status_e   status;
  } rule_verdict_t;

  rule_verdict_t verdict_q[$];
  rule_verdict_t head;
  rule_verdict_t guess;

  // Shadow registers and tables
  logic [CNT_W-1:0]  seq_len_q;
  logic [PORT_W-1:0] port_q [MAX_KNOCKS];
  logic              trk_vld  [TRACK_ENTRIES];
  logic [IP_W-1:0]   trk_ip   [TRACK_ENTRIES];
  logic [CNT_W-1:0]  trk_cnt  [TRACK_ENTRIES];
  logic              trk_miss [TRACK_ENTRIES];
  logic              opn_vld  [OPEN_ENTRIES];
  logic [IP_W-1:0]   opn_ip   [OPEN_ENTRIES];

  task automatic report_mismatch(input string what, input logic [IP_W-1:0] ip,
                                 input logic [IP_W-1:0] got, input logic [IP_W-1:0] want);
    fail_count_o++;
    $display("[%0t] mismatch on %s for host %08h: got %0h, expected %0h",
             $time, what, ip, got, want);
  endtask

  // Work out the rule command and status for one knock and update the tables
  function automatic rule_verdict_t judge_knock(input logic [IP_W-1:0] ip,
                                                input logic [PORT_W-1:0] port,
                                                input logic ok);
    rule_verdict_t v;
    int t;
    int o;
    int unsigned len;
    int unsigned pos;
    v.cmd    = CMD_NONE;
    v.ip     = ip;
    v.status = ST_IN_PROGRESS;
    len = seq_len_q;
    if (len < 1) len = 1;
    if (len > MAX_KNOCKS) len = MAX_KNOCKS;

    t = -1;
    for (int i = TRACK_ENTRIES - 1; i >= 0; i--)
      if (trk_vld[i] && trk_ip[i] == ip) t = i;

    // A bad hash drops whatever progress the source had
    if (!ok) begin
      if (t >= 0) trk_vld[t] = 1'b0;
      v.status = ST_BAD_HASH;
      return v;
    end

    // New source takes the lowest free slot
    if (t < 0) begin
      for (int i = TRACK_ENTRIES - 1; i >= 0; i--)
        if (!trk_vld[i]) t = i;
      if (t >= 0) begin
        trk_vld[t]  = 1'b1;
        trk_ip[t]   = ip;
        trk_cnt[t]  = '0;
        trk_miss[t] = 1'b0;
      end
    end
    if (t < 0) begin
      v.status = ST_TABLE_FULL;
      return v;
    end

    pos = trk_cnt[t];
    if (pos >= MAX_KNOCKS) trk_miss[t] = 1'b1;
    else if (port != port_q[CNT_W'(pos)]) trk_miss[t] = 1'b1;
    pos = pos + 1;
    trk_cnt[t] = CNT_W'(pos);

    // Sequence finished: free the slot, then, if no knock was out of order, toggle the source in the open set
    if (pos >= len) begin
      trk_vld[t] = 1'b0;
      if (trk_miss[t]) begin
        v.status = ST_OUT_OF_ORDER;
      end else begin
        o = -1;
        for (int i = OPEN_ENTRIES - 1; i >= 0; i--)
          if (opn_vld[i] && opn_ip[i] == ip) o = i;
        if (o >= 0) begin
          opn_vld[o] = 1'b0;
          v.cmd      = CMD_CLOSE;
          v.status   = ST_COMPLETE;
        end else begin
          for (int i = OPEN_ENTRIES - 1; i >= 0; i--)
            if (!opn_vld[i]) o = i;
          if (o >= 0) begin
            opn_vld[o] = 1'b1;
            opn_ip[o]  = ip;
            v.cmd      = CMD_OPEN;
            v.status   = ST_COMPLETE;
          end else begin
            v.status = ST_TABLE_FULL;
          end
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q = CNT_W'(LEN_RESET);
      for (int i = 0; i < MAX_KNOCKS; i++) port_q[i] = '0;
      for (int i = 0; i < TRACK_ENTRIES; i++) trk_vld[i] = 1'b0;
      for (int i = 0; i < OPEN_ENTRIES; i++) opn_vld[i] = 1'b0;
      verdict_q.delete();
    end else begin
      // Follow register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEQ_LEN: seq_len_q = cfg_data_i[CNT_W-1:0];
          REG_PORT_0, REG_PORT_1, REG_PORT_2,
          REG_PORT_3, REG_PORT_4, REG_PORT_5: begin
            port_q[cfg_idx_i - REG_PORT_0] = cfg_data_i[PORT_W-1:0];
          end
          default: ;
        endcase
      end

      // Predict each knock transfer
      if (knock_i.valid && knock_i.ready) begin
        guess = judge_knock(knock_i.source_ip, knock_i.dest_port, knock_i.hash_valid);
        verdict_q.insert(verdict_q.size(), guess);
        knocks_o++;
      end

      // Compare each result transfer with the oldest prediction
      if (result_i.valid && result_i.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result", result_i.rule_ip,
                          IP_W'(result_i.knock_status), '0);
        end else begin
          head = verdict_q.pop_front();
          if (result_i.rule_command !== head.cmd)
            report_mismatch("rule_command", head.ip, IP_W'(result_i.rule_command),
                            IP_W'(head.cmd));
          if (result_i.rule_ip !== head.ip)
            report_mismatch("rule_ip", head.ip, result_i.rule_ip, head.ip);
          if (result_i.knock_status !== head.status)
            report_mismatch("knock_status", head.ip, IP_W'(result_i.knock_status),
                            IP_W'(head.status));
        end
        case (result_i.rule_command)
          CMD_OPEN:  opens_o++;
          CMD_CLOSE: closes_o++;
          default: ;
        endcase
        case (result_i.knock_status)
          ST_OUT_OF_ORDER: disorder_o++;
          ST_BAD_HASH:     bad_hash_o++;
          ST_TABLE_FULL:   full_hits_o++;
          default: ;
        endcase
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import pkst_pkg::*;

  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_KNOCKS = 170;
  localparam int unsigned HOSTS        = 40;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pkst_knock_if  knock_if ();
  pkst_result_if result_if ();

  int unsigned fail_count, pending, knocks, opens, closes, disorder, bad_hash, full_hits;

  // Stimulus-side view of the sequence and of each host's progress
  logic              idle_on;
  logic [PORT_W-1:0] knock_seq [MAX_KNOCKS];
  int unsigned       knock_len;
  logic [IP_W-1:0]   host_pool [HOSTS];
  int unsigned       host_step [HOSTS];
  logic [IP_W-1:0]   stray_hosts[$];

  port_knock_sequence_tracker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .knock_i    (knock_if),
    .result_o   (result_if)
  );

  pkst_knock_checker knock_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .knock_i      (knock_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .knocks_o     (knocks),
    .opens_o      (opens),
    .closes_o     (closes),
    .disorder_o   (disorder),
    .bad_hash_o   (bad_hash),
    .full_hits_o  (full_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one knock after a random gap when idle_on is set and hold it until the transfer
  task automatic send_knock(input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
                            input logic ok);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      knock_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    knock_if.valid      <= 1'b1;
    knock_if.source_ip  <= ip;
    knock_if.dest_port  <= port;
    knock_if.hash_valid <= ok;
    @(posedge clk_i);
    while (!knock_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off until every predicted result has been seen
  task automatic drain_results();
    knock_if.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Write the length word and all six ports from knock_seq while idle, then the spare register if asked
  task automatic load_config(input logic [CFG_DATA_W-1:0] len_word, input logic spare);
    drain_results();
    repeat (2) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SEQ_LEN;
    cfg_data_i <= len_word;
    @(negedge clk_i);
    for (int i = 0; i < MAX_KNOCKS; i++) begin
      cfg_idx_i  <= CFG_IDX_W'(int'(REG_PORT_0) + i);
      cfg_data_i <= knock_seq[i];
      @(negedge clk_i);
    end
    if (spare) begin
      cfg_idx_i  <= SPARE_REG;
      cfg_data_i <= CFG_DATA_W'($urandom);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    knock_len = len_word[CNT_W-1:0];
    if (knock_len < 1) knock_len = 1;
    if (knock_len > MAX_KNOCKS) knock_len = MAX_KNOCKS;
  endtask

  function automatic void bump_host(input int unsigned h);
    host_step[h] = (host_step[h] + 1 >= knock_len) ? 0 : host_step[h] + 1;
  endfunction

  // Result side: when idle_on is set, stall for a random time before each transfer
  initial begin
    int unsigned stall;
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(result_if.valid && result_if.ready)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned pool_n;
    int unsigned prev_n;
    int unsigned h;
    int unsigned roll;
    int unsigned style;
    int unsigned len;
    logic [IP_W-1:0] ip;
    logic            ok;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_SEQ_LEN;
    cfg_data_i          = '0;
    knock_if.valid      = 1'b0;
    knock_if.source_ip  = '0;
    knock_if.dest_port  = '0;
    knock_if.hash_valid = 1'b0;
    idle_on             = 1'b1;
    knock_len           = LEN_RESET;
    for (int i = 0; i < MAX_KNOCKS; i++) knock_seq[i] = '0;

    host_pool[0] = '0;
    host_pool[1] = '1;
    for (int i = 2; i < HOSTS; i++) host_pool[i] = $urandom;
    for (int i = 0; i < HOSTS; i++) host_step[i] = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset sequence (length 3, ports zero): open host zero
    repeat (3) send_knock('0, '0, 1'b1);
    // Wrong first port from the all-ones host: out of order on the third
    send_knock('1, '1, 1'b1);
    repeat (2) send_knock('1, '0, 1'b1);
    // Same host zero again: close
    repeat (3) send_knock('0, '0, 1'b1);
    // Bad hash with no slot, then with a slot that it clears
    send_knock(32'h1234_5678, '0, 1'b0);
    send_knock(32'h0a00_0001, '0, 1'b1);
    send_knock(32'h0a00_0001, '0, 1'b0);
    repeat (3) send_knock(32'h0a00_0001, '0, 1'b1);

    // Length zero acts as one: each knock on the top port toggles
    knock_seq[0] = '1;
    load_config('0, 1'b0);
    repeat (2) send_knock(32'h8000_0000, '1, 1'b1);

    // Length seven acts as six; one knock in, then lower the length
    for (int i = 0; i < MAX_KNOCKS; i++) knock_seq[i] = PORT_W'(i + 1);
    load_config(CFG_DATA_W'(7), 1'b0);
    send_knock(32'hc0a8_0001, knock_seq[0], 1'b1);
    load_config(CFG_DATA_W'(1), 1'b1);
    send_knock(32'hc0a8_0001, knock_seq[1], 1'b1);

    // Random phases: mostly well-formed sequences from a pool of hosts
    prev_n = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: pool_n = 40;
        1: pool_n = 6;
        2: pool_n = 16;
        default: pool_n = 2;
      endcase

      // Free slots held by hosts leaving the pool and by stray sources
      for (int i = pool_n; i < prev_n; i++) begin
        send_knock(host_pool[i], PORT_W'($urandom), 1'b0);
        host_step[i] = 0;
      end
      while (stray_hosts.size() != 0)
        send_knock(stray_hosts.pop_front(), PORT_W'($urandom), 1'b0);
      prev_n = pool_n;

      case (phase)
        0: len = 1;
        1: len = MAX_KNOCKS;
        2: len = 0;
        3: len = 7;
        default: len = $urandom_range(0, 7);
      endcase
      style = $urandom_range(0, 3);
      for (int i = 0; i < MAX_KNOCKS; i++) begin
        case (style)
          0: knock_seq[i] = PORT_W'($urandom);
          1: knock_seq[i] = '0;
          2: knock_seq[i] = '1;
          default: knock_seq[i] = $urandom_range(0, 1) ? 16'h1f90 : 16'h0016;
        endcase
      end
      load_config({(CFG_DATA_W-CNT_W)'($urandom), CNT_W'(len)}, phase % 3 == 0);
      idle_on = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);

      for (int k = 0; k < PHASE_KNOCKS; k++) begin
        h    = $urandom_range(0, pool_n - 1);
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 59) == 0) drain_results();
        if (roll < 72) begin
          send_knock(host_pool[h], knock_seq[host_step[h]], 1'b1);
          bump_host(h);
        end else if (roll < 84) begin
          send_knock(host_pool[h], PORT_W'($urandom), 1'b1);
          bump_host(h);
        end else if (roll < 92) begin
          send_knock(host_pool[h], PORT_W'($urandom), 1'b0);
          host_step[h] = 0;
        end else if (roll < 96) begin
          ip = $urandom;
          ok = $urandom_range(0, 1);
          send_knock(ip, PORT_W'($urandom), ok);
          if (ok) stray_hosts.insert(stray_hosts.size(), ip);
        end else begin
          // skip ahead one position in the sequence
          send_knock(host_pool[h], knock_seq[(host_step[h] + 1) % MAX_KNOCKS], 1'b1);
          bump_host(h);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d knocks over %0d random register settings:",
             knocks, PHASES);
    $display("%0d opens, %0d closes, %0d out of order, %0d bad hash, %0d table full",
             opens, closes, disorder, bad_hash, full_hits);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
